@@ hdl/aftaa_pkg.sv @@
// Shared types, register indexes, CRC and arctangent table for the tilt averager.
package aftaa_pkg;

  typedef struct packed {
    logic [31:0] x_frame;
    logic [31:0] y_frame;
    logic [31:0] z_frame;
  } item_t;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } result_t;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] sz;
  } sample_t;

  typedef struct packed {
    logic [15:0] gain_x;
    logic [15:0] gain_y;
    logic [15:0] gain_z;
    logic [17:0] offset_x;
    logic [17:0] offset_y;
    logic [17:0] offset_z;
  } cfg_t;

  localparam logic [2:0] REG_GAIN_X   = 3'd0;
  localparam logic [2:0] REG_GAIN_Y   = 3'd1;
  localparam logic [2:0] REG_GAIN_Z   = 3'd2;
  localparam logic [2:0] REG_OFFSET_X = 3'd3;
  localparam logic [2:0] REG_OFFSET_Y = 3'd4;
  localparam logic [2:0] REG_OFFSET_Z = 3'd5;

  localparam logic [15:0] GAIN_X_RST   = 16'd16415;
  localparam logic [15:0] GAIN_Y_RST   = 16'd16427;
  localparam logic [15:0] GAIN_Z_RST   = 16'd16409;
  localparam logic [17:0] OFFSET_X_RST = 18'd58;
  localparam logic [17:0] OFFSET_Y_RST = 18'd156;
  localparam logic [17:0] OFFSET_Z_RST = 18'd41;

  localparam logic [7:0] CRC_POLY = 8'h1D;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic signed [16:0] ANGLE_LIMIT = 17'sd23040;

  // CRC-8 over the status and data bytes, checked against the low byte.
  function automatic logic frame_ok(input logic [31:0] frame);
    logic [7:0] crc;
    logic       fb;
    crc = CRC_INIT;
    for (int i = 31; i > 7; i--) begin
      fb  = crc[7] ^ frame[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return (~crc) == frame[7:0];
  endfunction

  // atan(2^-i) in degrees scaled by 65536.
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/accel_frame_tilt_angle_averager_unit.sv @@
// Top level of the tilt-angle averager: frame check in front, angle math in the back end.
// The back end works on one request at a time: calibration of the three axes, then for
// each axis the square root, the CORDIC loop and the sum for that axis.
// A request that closes an averaging window also forms the three averages.
// Requests are taken one at a time; a two-entry queue takes new requests meanwhile.
// Synchronous reset restores the register defaults and clears samples, sums and the count.
module accel_frame_tilt_angle_averager_unit #(
  parameter int AVG_COUNT    = 10,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  aftaa_pkg::item_t    item,
  input  logic                push,
  output logic                full,
  output aftaa_pkg::result_t  result,
  output logic                empty,
  input  logic                pop,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import aftaa_pkg::*;

  cfg_t    cfg;
  logic    q_push, q_full, q_pop, q_empty;
  sample_t q_wdata, q_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{gain_x: GAIN_X_RST, gain_y: GAIN_Y_RST, gain_z: GAIN_Z_RST,
               offset_x: OFFSET_X_RST, offset_y: OFFSET_Y_RST, offset_z: OFFSET_Z_RST};
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_GAIN_X:   cfg.gain_x   <= pwdata[15:0];
        REG_GAIN_Y:   cfg.gain_y   <= pwdata[15:0];
        REG_GAIN_Z:   cfg.gain_z   <= pwdata[15:0];
        REG_OFFSET_X: cfg.offset_x <= pwdata[17:0];
        REG_OFFSET_Y: cfg.offset_y <= pwdata[17:0];
        REG_OFFSET_Z: cfg.offset_z <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_GAIN_X:   prdata = {16'b0, cfg.gain_x};
      REG_GAIN_Y:   prdata = {16'b0, cfg.gain_y};
      REG_GAIN_Z:   prdata = {16'b0, cfg.gain_z};
      REG_OFFSET_X: prdata = {14'b0, cfg.offset_x};
      REG_OFFSET_Y: prdata = {14'b0, cfg.offset_y};
      REG_OFFSET_Z: prdata = {14'b0, cfg.offset_z};
      default:      prdata = '0;
    endcase
  end

  aftaa_front u_front (
    .clk(clk), .rst(rst), .item(item), .push(push), .full(full),
    .q_push(q_push), .q_data(q_wdata), .q_full(q_full)
  );

  aftaa_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  aftaa_back #(.AVG_COUNT(AVG_COUNT), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(q_empty), .q_data(q_rdata),
    .q_pop(q_pop), .result(result), .empty(empty), .pop(pop)
  );
endmodule

@@ hdl/aftaa_front.sv @@
// Front end: frame CRC check, last good sample per axis, hand-off to the queue.
module aftaa_front (
  input  logic             clk,
  input  logic             rst,
  input  aftaa_pkg::item_t item,
  input  logic             push,
  output logic             full,
  output logic             q_push,
  output aftaa_pkg::sample_t q_data,
  input  logic             q_full
);
  import aftaa_pkg::*;

  logic [15:0] last_x, last_y, last_z;
  logic [15:0] new_x, new_y, new_z;

  assign new_x = frame_ok(item.x_frame) ? item.x_frame[23:8] : last_x;
  assign new_y = frame_ok(item.y_frame) ? item.y_frame[23:8] : last_y;
  assign new_z = frame_ok(item.z_frame) ? item.z_frame[23:8] : last_z;

  assign full   = q_full;
  assign q_push = push && !q_full;
  assign q_data = '{sx: new_x, sy: new_y, sz: new_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= '0;
      last_y <= '0;
      last_z <= '0;
    end else if (q_push) begin
      last_x <= new_x;
      last_y <= new_y;
      last_z <= new_z;
    end
  end
endmodule

@@ hdl/aftaa_queue.sv @@
// Two-entry queue of checked samples between the front and back ends.
module aftaa_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  aftaa_pkg::sample_t wdata,
  output logic               full,
  input  logic               pop,
  output aftaa_pkg::sample_t rdata,
  output logic               empty
);
  import aftaa_pkg::*;

  sample_t    mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ hdl/aftaa_back.sv @@
// Back end: calibration, square root, CORDIC angle, summing and averaging.
module aftaa_back #(
  parameter int AVG_COUNT    = 10,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  aftaa_pkg::cfg_t    cfg,
  input  logic               q_empty,
  input  aftaa_pkg::sample_t q_data,
  output logic               q_pop,
  output aftaa_pkg::result_t result,
  output logic               empty,
  input  logic               pop
);
  import aftaa_pkg::*;

  localparam int CW = $clog2(AVG_COUNT + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(AVG_COUNT - 1);
  localparam logic [24:0] HALF = 25'(AVG_COUNT / 2);
  localparam logic [4:0] ROT_LAST = 5'(CORDIC_STEPS - 1);
  // Reciprocal of AVG_COUNT scaled by 2^28, rounded up; exact for the sums a window can reach.
  localparam logic [28:0] RECIP = 29'(((2 ** 28) + AVG_COUNT - 1) / AVG_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_CAL, S_SQB, S_SQC, S_ROOT, S_ROT, S_ACC, S_DIVL, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic [1:0] k;
  logic [15:0] samp [3];
  logic signed [20:0] v [3];
  logic [41:0] rn, res, bitm;
  logic signed [33:0] x, y;
  logic signed [24:0] z;
  logic [4:0] i;
  logic signed [23:0] sum [3];
  logic [CW-1:0] cnt;
  logic [24:0] dq;
  logic neg;
  logic [15:0] avg [3];
  logic out_valid;
  result_t out_data;

  logic signed [20:0] a, b, c, sq_op;
  logic [15:0] gain;
  logic [17:0] offset;
  logic signed [32:0] prod, prodr;
  logic signed [20:0] cal;
  logic signed [41:0] sq;
  logic [41:0] trial;
  logic signed [33:0] xs, ys;
  logic signed [24:0] zr;
  logic signed [16:0] q, qc;
  logic [53:0] qprod;
  logic [15:0] quo;
  logic [23:0] mag;

  always_comb begin
    a = v[k];
    b = (k == 2'd0) ? v[1] : v[0];
    c = (k == 2'd2) ? v[1] : v[2];
    case (k)
      2'd0: begin gain = cfg.gain_x; offset = cfg.offset_x; end
      2'd1: begin gain = cfg.gain_y; offset = cfg.offset_y; end
      default: begin gain = cfg.gain_z; offset = cfg.offset_z; end
    endcase
    prod  = $signed(samp[k]) * $signed({1'b0, gain});
    prodr = prod + 33'sd2048;
    cal   = prodr[32:12] + $signed({{3{offset[17]}}, offset});
    sq_op = (state == S_SQB) ? b : c;
    sq    = sq_op * sq_op;
    trial = res + bitm;
    xs    = x >>> i;
    ys    = y >>> i;
    zr    = z + 25'sd128;
    q     = zr[24:8];
    if (q > ANGLE_LIMIT) qc = ANGLE_LIMIT;
    else if (q < -ANGLE_LIMIT) qc = -ANGLE_LIMIT;
    else qc = q;
    qprod = dq * RECIP;
    quo   = qprod[43:28];
    mag   = sum[k][23] ? 24'(-sum[k]) : 24'(sum[k]);
  end

  assign q_pop  = (state == S_IDLE) && !q_empty;
  assign empty  = !out_valid;
  assign result = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= 2'd0;
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int n = 0; n < 3; n++) sum[n] <= '0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            samp[0] <= q_data.sx;
            samp[1] <= q_data.sy;
            samp[2] <= q_data.sz;
            k       <= 2'd0;
            state   <= S_CAL;
          end
        end
        S_CAL: begin
          v[k] <= cal;
          if (k == 2'd2) begin
            k     <= 2'd0;
            state <= S_SQB;
          end else begin
            k <= k + 2'd1;
          end
        end
        S_SQB: begin
          rn    <= 42'(sq);
          state <= S_SQC;
        end
        S_SQC: begin
          rn    <= rn + 42'(sq);
          res   <= '0;
          bitm  <= 42'd1 << 40;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (bitm == '0) begin
            i <= 5'd0;
            if (res == '0) begin
              if (a > 0) z <= 25'sd5898240;
              else if (a < 0) z <= -25'sd5898240;
              else z <= '0;
              state <= S_ACC;
            end else begin
              x     <= $signed({4'b0, res[21:0], 8'b0});
              y     <= $signed({{5{a[20]}}, a, 8'b0});
              z     <= '0;
              state <= S_ROT;
            end
          end else begin
            if (rn >= trial) begin
              rn  <= rn - trial;
              res <= (res >> 1) + bitm;
            end else begin
              res <= res >> 1;
            end
            bitm <= bitm >> 2;
          end
        end
        S_ROT: begin
          // Vectoring mode: drive y toward zero, collecting the angle in z.
          if (y > 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + $signed({3'b0, atan_deg(i)});
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - $signed({3'b0, atan_deg(i)});
          end
          i <= i + 5'd1;
          if (i == ROT_LAST) state <= S_ACC;
        end
        S_ACC: begin
          sum[k] <= sum[k] + 24'(qc);
          if (k == 2'd2) begin
            k <= 2'd0;
            if (cnt == CNT_LAST) begin
              cnt   <= '0;
              state <= S_DIVL;
            end else begin
              cnt   <= cnt + CW'(1);
              state <= S_IDLE;
            end
          end else begin
            k     <= k + 2'd1;
            state <= S_SQB;
          end
        end
        S_DIVL: begin
          dq    <= {1'b0, mag} + HALF;
          neg   <= sum[k][23];
          state <= S_DIV;
        end
        S_DIV: begin
          avg[k] <= neg ? -quo : quo;
          sum[k] <= '0;
          if (k == 2'd2) begin
            k     <= 2'd0;
            state <= S_OUT;
          end else begin
            k     <= k + 2'd1;
            state <= S_DIVL;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_data  <= '{angle_x: avg[0], angle_y: avg[1], angle_z: avg[2]};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ dv/tb_accel_frame_tilt_angle_averager_unit.sv @@
// Testbench for the tilt-angle averager: directed table, random frames, angle predictor.
module tb_accel_frame_tilt_angle_averager_unit;
  import aftaa_pkg::*;

  localparam int AVG_N       = 10;
  localparam int CORDIC_N    = 16;
  localparam int LIMIT       = 23040;
  localparam int RUN_LIMIT   = 3000000;
  localparam int DRAIN_WAIT  = 600;

  logic        clk;
  logic        rst;
  item_t       item;
  logic        push;
  logic        full;
  result_t     result;
  logic        empty;
  logic        pop;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  accel_frame_tilt_angle_averager_unit uut (
    .clk(clk), .rst(rst), .item(item), .push(push), .full(full),
    .result(result), .empty(empty), .pop(pop),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state.
  logic [15:0] gain_m [3];
  logic [17:0] offs_m [3];
  logic [15:0] good_sample [3];
  longint      angle_acc [3];
  int          window_fill;

  result_t     pending_angles [$];
  int          errors;
  longint      cycle_cnt;
  int          hold_off;
  logic        pause_pop;
  bit          stim_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
    errors++;
  endtask

  function automatic logic [7:0] crc_of(input logic [31:0] f);
    logic [7:0] c;
    logic       fb;
    c = 8'hFF;
    for (int i = 31; i > 7; i--) begin
      fb = c[7] ^ f[i];
      c  = {c[6:0], 1'b0} ^ (fb ? 8'h1D : 8'h00);
    end
    return ~c;
  endfunction

  function automatic longint shr_arith(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(input longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint atan_step(input int i);
    longint tbl [24];
    tbl = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  function automatic longint tilt_deg(input longint a, input longint b, input longint c);
    longint d, x, y, z, xs, ys, q;
    d = root_floor(b * b + c * c);
    if (d == 0) return (a > 0) ? LIMIT : ((a < 0) ? -LIMIT : 0);
    x = d * 256;
    y = a * 256;
    z = 0;
    for (int i = 0; i < CORDIC_N && i < 24; i++) begin
      xs = shr_arith(x, i);
      ys = shr_arith(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    q = shr_arith(z + 128, 8);
    if (q > LIMIT) q = LIMIT;
    if (q < -LIMIT) q = -LIMIT;
    return q;
  endfunction

  function automatic longint calibrated(input int ax);
    longint p;
    p = longint'($signed(good_sample[ax])) * longint'(gain_m[ax]);
    return shr_arith(p + 2048, 12) + longint'($signed(offs_m[ax]));
  endfunction

  function automatic logic [15:0] rounded_mean(input longint s);
    longint m, r;
    m = (s < 0) ? -s : s;
    r = (m + AVG_N / 2) / AVG_N;
    return (s < 0) ? 16'(-r) : 16'(r);
  endfunction

  // Advances the predictor by one request; returns 1 when a window closes.
  function automatic bit predict_angles(input item_t it, output result_t r);
    logic [31:0] f [3];
    longint v [3];
    f = '{it.x_frame, it.y_frame, it.z_frame};
    for (int i = 0; i < 3; i++)
      if (crc_of(f[i]) == f[i][7:0]) good_sample[i] = f[i][23:8];
    for (int i = 0; i < 3; i++) v[i] = calibrated(i);
    angle_acc[0] += tilt_deg(v[0], v[1], v[2]);
    angle_acc[1] += tilt_deg(v[1], v[0], v[2]);
    angle_acc[2] += tilt_deg(v[2], v[0], v[1]);
    window_fill++;
    r = '0;
    if (window_fill < AVG_N) return 0;
    r.angle_x = rounded_mean(angle_acc[0]);
    r.angle_y = rounded_mean(angle_acc[1]);
    r.angle_z = rounded_mean(angle_acc[2]);
    for (int i = 0; i < 3; i++) angle_acc[i] = 0;
    window_fill = 0;
    return 1;
  endfunction

  function automatic logic [31:0] good_frame(input logic [7:0] st, input logic [15:0] d);
    logic [31:0] f;
    f = {st, d, 8'h00};
    f[7:0] = crc_of(f);
    return f;
  endfunction

  function automatic logic [31:0] rand_frame();
    logic [31:0] f;
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: f = $urandom();
      1: begin
        f = good_frame(8'($urandom()), 16'($urandom()));
        f[$urandom_range(0, 31)] ^= 1'b1;
      end
      2: f = good_frame(8'($urandom()), $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
      3: f = good_frame(8'($urandom()), 16'($signed($urandom_range(0, 200)) - 100));
      4: f = good_frame(8'($urandom()), 16'h0000);
      default: f = good_frame(8'($urandom()), 16'($urandom()));
    endcase
    return f;
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_GAIN_X:   gain_m[0] = val[15:0];
      REG_GAIN_Y:   gain_m[1] = val[15:0];
      REG_GAIN_Z:   gain_m[2] = val[15:0];
      REG_OFFSET_X: offs_m[0] = val[17:0];
      REG_OFFSET_Y: offs_m[1] = val[17:0];
      REG_OFFSET_Z: offs_m[2] = val[17:0];
      default: ;
    endcase
  endtask

  // Requests that end a window add an expectation; others just advance state.
  task automatic send_request(input item_t it);
    result_t r;
    push = 1'b1;
    item = it;
    @(posedge clk);
    while (full) @(posedge clk);
    if (predict_angles(it, r)) pending_angles.push_back(r);
    @(negedge clk);
    push = 1'b0;
    item = '0;
  endtask

  task automatic sender_gap();
    int g;
    g = $urandom_range(0, 99);
    if (g < 60) return;
    repeat ((g < 95) ? $urandom_range(1, 3) : $urandom_range(20, 150)) @(negedge clk);
  endtask

  task automatic drain_idle();
    while (pending_angles.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic random_cfg(input bit extreme);
    for (int i = 0; i < 3; i++)
      cfg_write(3'(i), extreme ? ($urandom_range(0, 1) ? 32'hFFFF : 32'h0)
                               : $urandom_range(15000, 18000));
    for (int i = 0; i < 3; i++)
      cfg_write(3'(REG_OFFSET_X + i), extreme ? ($urandom_range(0, 1) ? 32'h1FFFF : 32'h20000)
                                              : 32'($signed($urandom_range(0, 800)) - 400));
  endtask

  // Result side: compare with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("unexpected result", result.angle_x, 0);
      end else begin
        want = pending_angles.pop_front();
        if (result.angle_x !== want.angle_x)
          report_mismatch("angle_x", result.angle_x, want.angle_x);
        if (result.angle_y !== want.angle_y)
          report_mismatch("angle_y", result.angle_y, want.angle_y);
        if (result.angle_z !== want.angle_z)
          report_mismatch("angle_z", result.angle_z, want.angle_z);
      end
    end
  end

  // Receiver stalls, with one long hold-off counted here.
  initial begin
    int g;
    pop = 1'b0;
    @(negedge clk);
    while (!stim_done || pending_angles.size() != 0) begin
      @(negedge clk);
      if (hold_off > 0) begin
        hold_off = hold_off - 1;
        pop <= 1'b0;
      end else if (pause_pop) begin
        pop <= 1'b0;
      end else begin
        g = $urandom_range(0, 99);
        pop <= (g < 70) || (cycle_cnt % 4000 < 1000);
      end
    end
    pop <= 1'b1;
  end

  typedef struct {
    logic [31:0] xf, yf, zf;
  } stim_row_t;

  initial begin
    stim_row_t rows [$];
    item_t it;
    int n;
    errors = 0; cycle_cnt = 0; hold_off = 0; pause_pop = 1'b0; stim_done = 0;
    rst = 1'b1; push = 1'b0; item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    gain_m = '{GAIN_X_RST, GAIN_Y_RST, GAIN_Z_RST};
    offs_m = '{OFFSET_X_RST, OFFSET_Y_RST, OFFSET_Z_RST};
    for (int i = 0; i < 3; i++) begin
      good_sample[i] = '0;
      angle_acc[i] = 0;
    end
    window_fill = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows: bad CRC before any good frame, extremes, zero samples on some axes.
    rows.push_back('{32'h0, 32'h0, 32'h0});
    rows.push_back('{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
    rows.push_back('{good_frame(8'h00, 16'h7FFF), good_frame(8'hFF, 16'h0000),
                     good_frame(8'h00, 16'h0000)});
    rows.push_back('{good_frame(8'hFF, 16'h8000), good_frame(8'h00, 16'h0000),
                     good_frame(8'hFF, 16'h0000)});
    rows.push_back('{good_frame(8'hA5, 16'h0000), good_frame(8'h5A, 16'h7FFF),
                     good_frame(8'h00, 16'h8000)});
    rows.push_back('{good_frame(8'h00, 16'hFFFF), 32'h12345678,
                     good_frame(8'h00, 16'h0001)});
    rows.push_back('{good_frame(8'h3C, 16'h7FFF), good_frame(8'hC3, 16'h7FFF),
                     good_frame(8'h00, 16'h7FFF)});
    rows.push_back('{good_frame(8'h00, 16'h8000), good_frame(8'h00, 16'h8000),
                     good_frame(8'h00, 16'h8000)});
    rows.push_back('{good_frame(8'h00, 16'h0100), good_frame(8'h00, 16'hFF00),
                     good_frame(8'h00, 16'h4000)});
    rows.push_back('{good_frame(8'h00, 16'h0000), good_frame(8'h00, 16'h0000),
                     good_frame(8'h00, 16'h0000)});
    foreach (rows[i]) begin
      it.x_frame = rows[i].xf; it.y_frame = rows[i].yf; it.z_frame = rows[i].zf;
      send_request(it);
    end
    drain_idle();

    // Zero gains and zero offsets give a zero denominator on every axis.
    for (int i = 0; i < 3; i++) cfg_write(3'(i), 32'h0);
    for (int i = 0; i < 3; i++) cfg_write(3'(REG_OFFSET_X + i), 32'h0);
    for (int i = 0; i < 10; i++) begin
      it.x_frame = rand_frame(); it.y_frame = rand_frame(); it.z_frame = rand_frame();
      send_request(it);
    end
    drain_idle();
    // A single nonzero offset on one axis gives exactly +-90 there.
    cfg_write(REG_OFFSET_Z, 32'h3FF00);
    for (int i = 0; i < 10; i++) begin
      it.x_frame = rand_frame(); it.y_frame = rand_frame(); it.z_frame = rand_frame();
      send_request(it);
    end
    drain_idle();

    n = 0;
    for (int phase = 0; phase < 6; phase++) begin
      random_cfg(phase == 1 || phase == 3);
      if (phase == 2) hold_off = 3000;
      for (int k = 0; k < 250; k++) begin
        it.x_frame = rand_frame(); it.y_frame = rand_frame(); it.z_frame = rand_frame();
        send_request(it);
        n++;
        if (phase != 2) sender_gap();
        if (k == 120) begin
          // Sender pauses until every expected result has come.
          while (pending_angles.size() != 0) @(negedge clk);
        end
      end
      drain_idle();
    end
    stim_done = 1;
    drain_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/aftaa_pkg.sv
hdl/aftaa_front.sv
hdl/aftaa_queue.sv
hdl/aftaa_back.sv
hdl/accel_frame_tilt_angle_averager_unit.sv
dv/tb_accel_frame_tilt_angle_averager_unit.sv
